// ----- rtl/kssp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kssp_pkg
// Shared types and constants for the shared-pool multi-stack block.
// ----------------------------------------------------------------------------
package kssp_pkg;

  // Pool geometry
  localparam int CAPACITY   = 16;
  localparam int NUM_STACKS = 4;

  // Field widths fixed by the interface
  localparam int SID_W  = 2;
  localparam int DATA_W = 32;

  // Slot index, and link pointer wide enough to hold the null link (CAPACITY)
  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int LINK_W = $clog2(CAPACITY + 1);
  localparam int HIDX_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(CAPACITY);

  typedef logic [LINK_W-1:0] link_t;

  // Request opcodes
  typedef enum logic {
    MODE_PUSH = 1'b0,
    MODE_POP  = 1'b1
  } mode_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_RSVD     = 2'd3
  } status_t;

  // Request sequencer
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Any pointer at or above CAPACITY terminates a list
  function automatic logic is_nil(input link_t link);
    is_nil = (link >= NIL_LINK);
  endfunction

endpackage

// ----- rtl/k_stacks_shared_pool.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_stacks_shared_pool
// Several LIFO stacks kept as linked lists in one slot pool with a free list.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------
//  in      | in_valid / in_stall    | mode, stack_id, push_value
//  out     | out_valid / out_stall  | status, pop_value, pool_full, stack_now_empty
//
// On accept a request reads the link and data memories at the free-list head
// (push) or stack head (pop); in S_EXEC it resolves the dependent link and
// writes the memories and head pointers back.
// in_stall is high in S_EXEC, and holds there while the result
// register is occupied and stalled. A finished result waits in the output
// register while the next request is taken. Reset is synchronous: no
// clearing pass, link entries are valid-tracked and read as i+1 until written.
module k_stacks_shared_pool
  import kssp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // request channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     mode,
  input  logic [SID_W-1:0]         stack_id,
  input  logic signed [DATA_W-1:0] push_value,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               status,
  output logic signed [DATA_W-1:0] pop_value,
  output logic                     pool_full,
  output logic                     stack_now_empty
);

  // Slot memories
  logic [DATA_W-1:0] data_mem [CAPACITY];
  link_t             link_mem [CAPACITY];
  logic [CAPACITY-1:0] link_vld;

  // Head pointers
  link_t stack_head [NUM_STACKS];
  link_t free_head;

  // Latched request and registered memory reads
  state_t            state, state_next;
  logic              req_mode;
  logic [HIDX_W-1:0] req_hidx;
  logic              req_sid_ok;
  logic [DATA_W-1:0] req_val;
  link_t             req_ptr;
  link_t             rd_link;
  logic              rd_vld;
  logic [DATA_W-1:0] rd_data;

  // Control
  logic in_fire;
  logic exec_fire;

  // Execute-cycle results
  link_t             link_eff;
  link_t             head_cur;
  link_t             head_new;
  link_t             free_next;
  link_t             wr_link;
  logic              wr_en;
  logic              data_wr_en;
  status_t           st_next;
  logic [DATA_W-1:0] popped;
  logic              empty_next;

  // Accept-cycle selection
  logic [HIDX_W-1:0] sid_idx;
  link_t             sel_ptr;
  logic [IDX_W-1:0]  sel_idx;
  logic [IDX_W-1:0]  req_idx;

  assign sid_idx = stack_id[HIDX_W-1:0];
  assign sel_ptr = (mode_t'(mode) == MODE_PUSH) ? free_head : stack_head[sid_idx];
  assign sel_idx = sel_ptr[IDX_W-1:0];
  assign req_idx = req_ptr[IDX_W-1:0];
  assign in_fire = in_valid && !in_stall;

  // Sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_fire) state_next = S_EXEC;
      S_EXEC: if (exec_fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_stall  = 1'b0;
    exec_fire = 1'b0;
    unique case (state)
      S_IDLE: in_stall = 1'b0;
      S_EXEC: begin
        in_stall  = 1'b1;
        exec_fire = !out_valid || !out_stall;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch request on accept
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_mode   <= mode;
      req_hidx   <= sid_idx;
      req_sid_ok <= (32'(stack_id) < NUM_STACKS);
      req_val    <= push_value;
      req_ptr    <= sel_ptr;
    end
  end

  // Data memory: read on accept, write on a successful push
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_data <= data_mem[sel_idx];
    end
    if (exec_fire && data_wr_en) begin
      data_mem[req_idx] <= req_val;
    end
  end

  // Link memory: read on accept, write back in the execute cycle
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_link <= link_mem[sel_idx];
    end
    if (exec_fire && wr_en) begin
      link_mem[req_idx] <= wr_link;
    end
  end

  // Link valid bits: an unwritten entry reads as its reset chain value
  always_ff @(posedge clk) begin
    if (rst) begin
      link_vld <= '0;
      rd_vld   <= 1'b0;
    end else begin
      if (in_fire) begin
        rd_vld <= link_vld[sel_idx];
      end
      if (exec_fire && wr_en) begin
        link_vld[req_idx] <= 1'b1;
      end
    end
  end

  // Execute: unlink / relink with the link just read
  always_comb begin
    link_eff   = rd_vld ? rd_link : (req_ptr + link_t'(1));
    head_cur   = stack_head[req_hidx];
    head_new   = head_cur;
    free_next  = free_head;
    wr_link    = head_cur;
    wr_en      = 1'b0;
    data_wr_en = 1'b0;
    st_next    = ST_OK;
    popped     = '0;
    if (!req_sid_ok) begin
      st_next = ST_EMPTY;
    end else if (mode_t'(req_mode) == MODE_PUSH) begin
      if (is_nil(free_head)) begin
        st_next = ST_OVERFLOW;
      end else begin
        free_next  = link_eff;
        head_new   = req_ptr;
        wr_link    = head_cur;
        wr_en      = 1'b1;
        data_wr_en = 1'b1;
      end
    end else begin
      if (is_nil(head_cur)) begin
        st_next = ST_EMPTY;
      end else begin
        head_new  = link_eff;
        free_next = req_ptr;
        wr_link   = free_head;
        wr_en     = 1'b1;
        popped    = rd_data;
      end
    end
    empty_next = !req_sid_ok || is_nil(head_new);
  end

  // Head pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        stack_head[i] <= NIL_LINK;
      end
      free_head <= '0;
    end else if (exec_fire) begin
      free_head <= free_next;
      if (req_sid_ok) begin
        stack_head[req_hidx] <= head_new;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      status          <= st_next;
      pop_value       <= popped;
      pool_full       <= is_nil(free_next);
      stack_now_empty <= empty_next;
    end
  end

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> in_stall)
    else $error("request accepted without entering execute cycle");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_OVERFLOW) |-> pool_full)
    else $error("overflow reported with free slots left");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_EMPTY) |-> (pop_value == '0 && stack_now_empty))
    else $error("empty result carries data or nonempty stack");

  a_no_rsvd_status: assert property (@(posedge clk) disable iff (rst)
    exec_fire |-> (st_next != ST_RSVD))
    else $error("reserved status code produced");

endmodule
